[hdl/gbq_pkg.sv]
// Shared types and constants for the gamepad button qualifier.
// Holds the payload structs, register codes and reset values; no dependencies.
package gbq_pkg;

   localparam int NUM_PADS_DEF        = 4;
   localparam int REPEAT_DELAY_DEF    = 20;
   localparam int REPEAT_INTERVAL_DEF = 7;

   localparam int NUM_BUTTONS = 32;
   localparam int CNT_W       = 32;
   localparam int PAD_W       = 2;
   localparam int AXIS_W      = 16;
   localparam int TRIG_W      = 8;
   localparam int THR_W       = 15;
   localparam int BTN_W       = 16;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   localparam logic [THR_W-1:0]  STICK_X_THR_RST = 15'd300;
   localparam logic [THR_W-1:0]  STICK_Y_THR_RST = 15'd25000;
   localparam logic [TRIG_W-1:0] TRIGGER_THR_RST = 8'd130;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_STICK_X = 2'd0;
   localparam logic [1:0] REG_STICK_Y = 2'd1;
   localparam logic [1:0] REG_TRIGGER = 2'd2;

   typedef struct packed {
      logic [PAD_W-1:0]         pad;
      logic                     connected;
      logic [BTN_W-1:0]         buttons;
      logic [TRIG_W-1:0]        left_trigger;
      logic [TRIG_W-1:0]        right_trigger;
      logic signed [AXIS_W-1:0] left_x;
      logic signed [AXIS_W-1:0] left_y;
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
   } req_type;

   typedef struct packed {
      logic [PAD_W-1:0]       pad_out;
      logic                   connected_out;
      logic [NUM_BUTTONS-1:0] held_mask;
      logic [NUM_BUTTONS-1:0] pressed_mask;
      logic [NUM_BUTTONS-1:0] released_mask;
      logic [NUM_BUTTONS-1:0] repeat_mask;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0]  x_thr;
      logic [THR_W-1:0]  y_thr;
      logic [TRIG_W-1:0] trig_thr;
   } thr_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] held;
      logic [NUM_BUTTONS-1:0] pressed;
      logic [NUM_BUTTONS-1:0] released;
      logic [NUM_BUTTONS-1:0] rpt;
   } masks_type;

endpackage

[hdl/gbq_csr.sv]
// Configuration registers of the button qualifier behind an APB-style port.
// Depends on gbq_pkg for register codes, widths and reset values.
module gbq_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gbq_pkg::CSR_AW-1:0]  paddr,
   input  logic [gbq_pkg::CSR_DW-1:0]  pwdata,
   output logic [gbq_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output gbq_pkg::thr_type            thr
);
   import gbq_pkg::*;

   logic [THR_W-1:0]  x_thr_ff, x_thr_in;
   logic [THR_W-1:0]  y_thr_ff, y_thr_in;
   logic [TRIG_W-1:0] trig_thr_ff, trig_thr_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[3:2];

   always_comb begin
      x_thr_in    = x_thr_ff;
      y_thr_in    = y_thr_ff;
      trig_thr_in = trig_thr_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_STICK_X: x_thr_in    = pwdata[THR_W-1:0];
            REG_STICK_Y: y_thr_in    = pwdata[THR_W-1:0];
            REG_TRIGGER: trig_thr_in = pwdata[TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_STICK_X: prdata = CSR_DW'(x_thr_ff);
         REG_STICK_Y: prdata = CSR_DW'(y_thr_ff);
         REG_TRIGGER: prdata = CSR_DW'(trig_thr_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_thr_ff    <= STICK_X_THR_RST;
         y_thr_ff    <= STICK_Y_THR_RST;
         trig_thr_ff <= TRIGGER_THR_RST;
      end else begin
         x_thr_ff    <= x_thr_in;
         y_thr_ff    <= y_thr_in;
         trig_thr_ff <= trig_thr_in;
      end
   end

   assign thr.x_thr    = x_thr_ff;
   assign thr.y_thr    = y_thr_ff;
   assign thr.trig_thr = trig_thr_ff;

endmodule

[hdl/gbq_mapper.sv]
// Maps one poll's buttons, triggers and stick axes onto the 32-bit held mask.
// Purely combinational; depends on gbq_pkg for the payload and threshold types.
module gbq_mapper (
   input  gbq_pkg::req_type                    req,
   input  gbq_pkg::thr_type                    thr,
   output logic [gbq_pkg::NUM_BUTTONS-1:0]     held
);
   import gbq_pkg::*;

   // Returns up, down, left, right in bits 0 to 3.
   function automatic logic [3:0] stick_bits(input logic signed [AXIS_W-1:0] x,
                                             input logic signed [AXIS_W-1:0] y,
                                             input logic [THR_W-1:0]         xt,
                                             input logic [THR_W-1:0]         yt);
      logic signed [AXIS_W:0] xs, ys, xp, yp, xn, yn;
      logic [3:0]             m;
      xs = {x[AXIS_W-1], x};
      ys = {y[AXIS_W-1], y};
      xp = signed'({2'b00, xt});
      yp = signed'({2'b00, yt});
      xn = -xp;
      yn = -yp;
      m[0] = (ys >= yp);
      m[1] = (ys <= yn);
      m[2] = (xs <= xn);
      m[3] = (xs >= xp);
      return m;
   endfunction

   always_comb begin
      held        = '0;
      held[9:0]   = req.buttons[9:0];
      held[13:10] = req.buttons[15:12];
      held[14]    = (req.left_trigger  >= thr.trig_thr);
      held[15]    = (req.right_trigger >= thr.trig_thr);
      held[27:24] = stick_bits(req.left_x,  req.left_y,  thr.x_thr, thr.y_thr);
      held[31:28] = stick_bits(req.right_x, req.right_y, thr.x_thr, thr.y_thr);
   end

endmodule

[hdl/gbq_state.sv]
// Per-pad mask stores and per-button hold counters with the auto-repeat rule.
// Depends on gbq_pkg; all 32 button lanes of the selected pad update together.
module gbq_state #(
   parameter int NUM_PADS        = gbq_pkg::NUM_PADS_DEF,
   parameter int REPEAT_DELAY    = gbq_pkg::REPEAT_DELAY_DEF,
   parameter int REPEAT_INTERVAL = gbq_pkg::REPEAT_INTERVAL_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gbq_pkg::PAD_W-1:0]           pad,
   input  logic                                connected,
   input  logic                                update,
   input  logic [gbq_pkg::NUM_BUTTONS-1:0]     now,
   output logic                                pad_ok,
   output gbq_pkg::masks_type                  masks
);
   import gbq_pkg::*;

   localparam int IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
   localparam int RES_W = (REPEAT_INTERVAL > 1) ? $clog2(REPEAT_INTERVAL) : 1;
   localparam logic [RES_W-1:0] RES_LAST  = RES_W'(REPEAT_INTERVAL - 1);
   localparam logic [CNT_W-1:0] DELAY_CNT = CNT_W'(REPEAT_DELAY);

   masks_type         store_ff [NUM_PADS];
   logic [CNT_W-1:0]  cnt_ff   [NUM_PADS][NUM_BUTTONS];
   // Residue of each counter modulo the repeat interval, kept beside it.
   logic [RES_W-1:0]  res_ff   [NUM_PADS][NUM_BUTTONS];

   logic [IDX_W-1:0]  idx;
   masks_type         cur;
   masks_type         nxt;
   logic [CNT_W-1:0]  cnt_rd [NUM_BUTTONS];
   logic [RES_W-1:0]  res_rd [NUM_BUTTONS];
   logic [CNT_W-1:0]  cnt_in [NUM_BUTTONS];
   logic [RES_W-1:0]  res_in [NUM_BUTTONS];

   assign idx    = IDX_W'(pad);
   assign pad_ok = (int'(pad) < NUM_PADS);

   always_comb begin
      cur = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         cnt_rd[i] = '0;
         res_rd[i] = '0;
      end
      if (pad_ok) begin
         cur = store_ff[idx];
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            cnt_rd[i] = cnt_ff[idx][i];
            res_rd[i] = res_ff[idx][i];
         end
      end
   end

   always_comb begin
      nxt.held     = now;
      nxt.pressed  = (cur.held ^ now) & now;
      nxt.released = (cur.held ^ now) & cur.held;
      nxt.rpt      = cur.rpt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (now[i]) begin
            cnt_in[i] = cnt_rd[i] + 1'b1;
            // A wrap lands on zero, which is a multiple of any interval.
            if (cnt_rd[i] == '1 || res_rd[i] == RES_LAST) begin
               res_in[i] = '0;
            end else begin
               res_in[i] = res_rd[i] + 1'b1;
            end
            if (cnt_in[i] >= DELAY_CNT) begin
               nxt.rpt[i] = (res_in[i] == '0);
            end
         end else begin
            cnt_in[i]  = '0;
            res_in[i]  = '0;
            nxt.rpt[i] = 1'b0;
         end
      end
   end

   always_comb begin
      if (!pad_ok) begin
         masks = '0;
      end else if (connected) begin
         masks = nxt;
      end else begin
         masks = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PADS; p++) begin
            store_ff[p] <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
               cnt_ff[p][i] <= '0;
               res_ff[p][i] <= '0;
            end
         end
      end else if (update && pad_ok) begin
         store_ff[idx] <= nxt;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            cnt_ff[idx][i] <= cnt_in[i];
            res_ff[idx][i] <= res_in[i];
         end
      end
   end

endmodule

[hdl/gamepad_button_qualifier_repeat_core.sv]
// Gamepad button qualifier: each poll beat maps one pad's buttons, triggers and
// sticks to a 32-bit held mask and returns held, pressed, released and repeat
// masks. A poll is registered in the input register on acceptance and its
// result in the result register once that register frees up; one poll is taken
// every cycle while results are not held back, the per-pad state being read and written
// between the input and result registers. A threshold write applies to every
// poll that leaves the input register after the write edge, including one that
// sat stalled there when the write happened. A disconnected poll returns the
// stored masks unchanged, and a pad number at or beyond NUM_PADS returns zero masks.
module gamepad_button_qualifier_repeat_core #(
   parameter int NUM_PADS        = gbq_pkg::NUM_PADS_DEF,
   parameter int REPEAT_DELAY    = gbq_pkg::REPEAT_DELAY_DEF,
   parameter int REPEAT_INTERVAL = gbq_pkg::REPEAT_INTERVAL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  gbq_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output gbq_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gbq_pkg::CSR_AW-1:0]  paddr,
   input  logic [gbq_pkg::CSR_DW-1:0]  pwdata,
   output logic [gbq_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import gbq_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   req_type                s1_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   logic                   advance;
   logic                   update;
   logic                   pad_ok;
   thr_type                thr;
   logic [NUM_BUTTONS-1:0] now;
   masks_type              masks;

   gbq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thr     (thr)
   );

   gbq_mapper u_mapper (
      .req  (s1_ff),
      .thr  (thr),
      .held (now)
   );

   gbq_state #(
      .NUM_PADS        (NUM_PADS),
      .REPEAT_DELAY    (REPEAT_DELAY),
      .REPEAT_INTERVAL (REPEAT_INTERVAL)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .pad       (s1_ff.pad),
      .connected (s1_ff.connected),
      .update    (update),
      .now       (now),
      .pad_ok    (pad_ok),
      .masks     (masks)
   );

   // The result register frees up when empty or when its beat is taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign update    = advance && s1_valid_ff && s1_ff.connected;

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_ff <= req_data;
      end
      if (advance && s1_valid_ff) begin
         rsp_ff.pad_out       <= s1_ff.pad;
         rsp_ff.connected_out <= s1_ff.connected && pad_ok;
         rsp_ff.held_mask     <= masks.held;
         rsp_ff.pressed_mask  <= masks.pressed;
         rsp_ff.released_mask <= masks.released;
         rsp_ff.repeat_mask   <= masks.rpt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A poll in the input register stays there while the result register is blocked.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ff))
      else $error("input register lost a poll while stalled");

   a_edges_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.pressed_mask & ~rsp_data.held_mask) == '0) &&
                    ((rsp_data.released_mask & rsp_data.held_mask) == '0))
      else $error("edge masks disagree with held mask");

   a_repeat_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.repeat_mask & ~rsp_data.held_mask) == '0))
      else $error("repeat set on a released button");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.held_mask[23:16] == '0))
      else $error("unused held bits set");

endmodule
